/* rtl/dtp_pkg.sv */
// Shared types and constants for the DER TLV header parser.
// Used by the parse stage, result queue, top level and testbench; depends on nothing else.
package dtp_pkg;

   // Bounds on the variable-length identifier and length fields.
   localparam int unsigned MAX_LEN_BYTES = 4;
   localparam int unsigned MAX_TAG_BYTES = 4;
   localparam int unsigned LEN_LEFT_W    = $clog2(MAX_LEN_BYTES + 1);
   localparam int unsigned TAG_SEEN_W    = $clog2(MAX_TAG_BYTES + 1);

   // Result queue geometry (a power of two, at least four entries).
   localparam int unsigned RSP_FIFO_DEPTH = 8;
   localparam int unsigned RSP_PTR_W      = $clog2(RSP_FIFO_DEPTH);
   localparam int unsigned RSP_CNT_W      = $clog2(RSP_FIFO_DEPTH + 1);

   // Result kinds.
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_CONTENT = 2'd1;
   localparam logic [1:0] KIND_INTEGER = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_LEN_LONG = 2'd1;
   localparam logic [1:0] ERR_TAG_LONG = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MATCH_CLASS       = 2'd0;
   localparam logic [1:0] CSR_MATCH_CONSTRUCTED = 2'd1;
   localparam logic [1:0] CSR_MATCH_TAG         = 2'd2;

   // Identifier and length byte fields.
   localparam logic [4:0] TAG_HIGH_FORM = 5'h1F;
   localparam logic [5:0] TAG_INTEGER   = 6'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  tag_class;
      logic        constructed;
      logic [31:0] tag_number;
      logic [31:0] length_value;
      logic        matches_res;
      logic [7:0]  content_byte;
      logic        last_of_run;
      logic [31:0] int_value;
      logic [1:0]  error_code;
   } dtp_result_type;

   // Up to two results produced by one input byte.
   typedef struct packed {
      logic [1:0]     count;
      dtp_result_type res0;
      dtp_result_type res1;
   } dtp_push_type;

   typedef struct packed {
      logic [1:0]  match_class;
      logic        match_constructed;
      logic [31:0] match_tag;
   } dtp_cfg_type;

endpackage

/* rtl/dtp_req_if.sv */
// Input channel of the DER TLV header parser: one stream byte per transaction.
// Stands alone; no package needed.
interface dtp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

/* rtl/dtp_rsp_if.sv */
// Result channel of the DER TLV header parser: one result per transaction.
// Stands alone; no package needed.
interface dtp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  tag_class;
   logic        constructed;
   logic [31:0] tag_number;
   logic [31:0] length_value;
   logic        matches_res;
   logic [7:0]  content_byte;
   logic        last_of_run;
   logic [31:0] int_value;
   logic [1:0]  error_code;

   modport source (output valid, output kind, output tag_class, output constructed,
                   output tag_number, output length_value, output matches_res,
                   output content_byte, output last_of_run, output int_value,
                   output error_code, input ready);
   modport sink   (input valid, input kind, input tag_class, input constructed,
                   input tag_number, input length_value, input matches_res,
                   input content_byte, input last_of_run, input int_value,
                   input error_code, output ready);
endinterface

/* rtl/dtp_parse.sv */
// Parse state machine: consumes one registered stream byte per cycle when
// byte_valid is high and produces up to two results. Depends on dtp_pkg.
module dtp_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_valid,
   input  logic [7:0]           byte_data,
   input  logic                 byte_start,
   input  dtp_pkg::dtp_cfg_type cfg,
   output dtp_pkg::dtp_push_type push
);

   localparam logic [2:0] PH_ID   = 3'd0;
   localparam logic [2:0] PH_TAGX = 3'd1;
   localparam logic [2:0] PH_LEN1 = 3'd2;
   localparam logic [2:0] PH_LENX = 3'd3;
   localparam logic [2:0] PH_BODY = 3'd4;

   logic [2:0]                       phase_ff, phase_in;
   logic [31:0]                      tag_accum_ff, tag_accum_in;
   logic [dtp_pkg::TAG_SEEN_W-1:0]   tag_seen_ff, tag_seen_in;
   logic [1:0]                       hdr_class_ff, hdr_class_in;
   logic                             hdr_form_ff, hdr_form_in;
   logic [31:0]                      len_accum_ff, len_accum_in;
   logic [dtp_pkg::LEN_LEFT_W-1:0]   len_left_ff, len_left_in;
   logic [31:0]                      content_left_ff, content_left_in;
   logic                             is_integer_ff, is_integer_in;
   logic [31:0]                      int_accum_ff, int_accum_in;

   logic [2:0]  cur_phase;
   logic        hdr_done;
   logic        hdr_integer;
   logic [6:0]  len_count;
   dtp_pkg::dtp_result_type res0, res1;
   logic [1:0]  res_count;

   // Next-state and result decode for one byte.
   always_comb begin
      phase_in        = phase_ff;
      tag_accum_in    = tag_accum_ff;
      tag_seen_in     = tag_seen_ff;
      hdr_class_in    = hdr_class_ff;
      hdr_form_in     = hdr_form_ff;
      len_accum_in    = len_accum_ff;
      len_left_in     = len_left_ff;
      content_left_in = content_left_ff;
      is_integer_in   = is_integer_ff;
      int_accum_in    = int_accum_ff;
      res0            = '0;
      res1            = '0;
      res_count       = 2'd0;
      hdr_done        = 1'b0;
      len_count       = byte_data[6:0];
      cur_phase       = byte_start ? PH_ID : phase_ff;

      unique case (cur_phase)
         PH_TAGX: begin
            if (tag_seen_ff >= dtp_pkg::TAG_SEEN_W'(dtp_pkg::MAX_TAG_BYTES)) begin
               res0.kind       = dtp_pkg::KIND_ERROR;
               res0.error_code = dtp_pkg::ERR_TAG_LONG;
               res_count       = 2'd1;
               phase_in        = PH_ID;
            end else begin
               tag_seen_in  = tag_seen_ff + 1'b1;
               tag_accum_in = {tag_accum_ff[24:0], byte_data[6:0]};
               phase_in     = byte_data[7] ? PH_TAGX : PH_LEN1;
            end
         end
         PH_LEN1: begin
            if (!byte_data[7]) begin
               len_accum_in = {24'd0, byte_data};
               hdr_done     = 1'b1;
            end else begin
               len_accum_in = 32'd0;
               if (len_count > 7'(dtp_pkg::MAX_LEN_BYTES)) begin
                  res0.kind       = dtp_pkg::KIND_ERROR;
                  res0.error_code = dtp_pkg::ERR_LEN_LONG;
                  res_count       = 2'd1;
                  phase_in        = PH_ID;
               end else if (len_count == 7'd0) begin
                  hdr_done = 1'b1;
               end else begin
                  len_left_in = dtp_pkg::LEN_LEFT_W'(len_count);
                  phase_in    = PH_LENX;
               end
            end
         end
         PH_LENX: begin
            len_accum_in = {len_accum_ff[23:0], byte_data};
            len_left_in  = len_left_ff - 1'b1;
            hdr_done     = (len_left_in == '0);
         end
         PH_BODY: begin
            res0.kind         = dtp_pkg::KIND_CONTENT;
            res0.content_byte = byte_data;
            res0.last_of_run  = (content_left_ff == 32'd1);
            res_count         = 2'd1;
            int_accum_in      = {int_accum_ff[23:0], byte_data};
            content_left_in   = content_left_ff - 32'd1;
            if (content_left_in == 32'd0) begin
               phase_in = PH_ID;
               if (is_integer_ff) begin
                  res1.kind      = dtp_pkg::KIND_INTEGER;
                  res1.int_value = int_accum_in;
                  res_count      = 2'd2;
               end
            end
         end
         default: begin
            // Identifier byte: also the recovery point for any unused code.
            hdr_class_in = byte_data[7:6];
            hdr_form_in  = byte_data[5];
            len_accum_in = 32'd0;
            len_left_in  = '0;
            tag_seen_in  = '0;
            if (byte_data[4:0] == dtp_pkg::TAG_HIGH_FORM) begin
               tag_accum_in = 32'd0;
               phase_in     = PH_TAGX;
            end else begin
               tag_accum_in = {27'd0, byte_data[4:0]};
               phase_in     = PH_LEN1;
            end
         end
      endcase

      // Header completion: emit the header and decide how the contents go.
      hdr_integer = (hdr_class_ff == 2'd0) && !hdr_form_ff &&
                    (tag_accum_ff == 32'(dtp_pkg::TAG_INTEGER));
      if (hdr_done) begin
         res0.kind         = dtp_pkg::KIND_HEADER;
         res0.tag_class    = hdr_class_ff;
         res0.constructed  = hdr_form_ff;
         res0.tag_number   = tag_accum_ff;
         res0.length_value = len_accum_in;
         res0.matches_res  = (hdr_class_ff == cfg.match_class) &&
                             (hdr_form_ff == cfg.match_constructed) &&
                             (tag_accum_ff == cfg.match_tag);
         res_count         = 2'd1;
         phase_in          = PH_ID;
         if (!hdr_form_ff) begin
            if (len_accum_in == 32'd0) begin
               if (hdr_integer) begin
                  res1.kind      = dtp_pkg::KIND_INTEGER;
                  res1.int_value = 32'd0;
                  res_count      = 2'd2;
               end
            end else begin
               content_left_in = len_accum_in;
               is_integer_in   = hdr_integer;
               int_accum_in    = 32'd0;
               phase_in        = PH_BODY;
            end
         end
      end
   end

   // Parse state registers advance only on a byte held in the input stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_ID;
         tag_accum_ff    <= 32'd0;
         tag_seen_ff     <= '0;
         hdr_class_ff    <= 2'd0;
         hdr_form_ff     <= 1'b0;
         len_accum_ff    <= 32'd0;
         len_left_ff     <= '0;
         content_left_ff <= 32'd0;
         is_integer_ff   <= 1'b0;
         int_accum_ff    <= 32'd0;
      end else if (byte_valid) begin
         phase_ff        <= phase_in;
         tag_accum_ff    <= tag_accum_in;
         tag_seen_ff     <= tag_seen_in;
         hdr_class_ff    <= hdr_class_in;
         hdr_form_ff     <= hdr_form_in;
         len_accum_ff    <= len_accum_in;
         len_left_ff     <= len_left_in;
         content_left_ff <= content_left_in;
         is_integer_ff   <= is_integer_in;
         int_accum_ff    <= int_accum_in;
      end
   end

   // Results go to the queue only for a real byte.
   always_comb begin
      push.count = byte_valid ? res_count : 2'd0;
      push.res0  = res0;
      push.res1  = res1;
   end

endmodule

/* rtl/dtp_rsp_fifo.sv */
// Result queue: takes up to two results a cycle, hands out one a cycle on each pop.
// Depends on dtp_pkg.
module dtp_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  dtp_pkg::dtp_push_type         push,
   input  logic                          pop,
   output dtp_pkg::dtp_result_type       head,
   output logic [dtp_pkg::RSP_CNT_W-1:0] fill_count
);

   dtp_pkg::dtp_result_type entry_ff [dtp_pkg::RSP_FIFO_DEPTH];
   logic [dtp_pkg::RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dtp_pkg::RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dtp_pkg::RSP_CNT_W-1:0] count_ff, count_in;
   logic [dtp_pkg::RSP_PTR_W-1:0] wr_ptr_next;

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_next = wr_ptr_ff + 1'b1;
      wr_ptr_in   = wr_ptr_ff + dtp_pkg::RSP_PTR_W'(push.count);
      rd_ptr_in   = rd_ptr_ff + dtp_pkg::RSP_PTR_W'(pop);
      count_in    = count_ff + dtp_pkg::RSP_CNT_W'(push.count)
                    - dtp_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage; the second result lands in the following slot.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.res1;
      end
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign fill_count = count_ff;

endmodule

/* rtl/der_tlv_header_parser_unit.sv */
// DER TLV header parser top level: input register, parse stage, result queue.
// A result passes through the input register and the result queue before it is offered.
// Throughput: one byte per cycle while the receiver does not stall and each byte
// yields at most one result; two-result bytes are paced by the one-result-per-cycle output.
// Reset (synchronous): parse state to identifier start, queue empty, match
// registers zero. Depends on dtp_pkg, dtp_req_if, dtp_rsp_if, dtp_parse, dtp_rsp_fifo.
module der_tlv_header_parser_unit (
   input  logic        clock,
   input  logic        reset,
   dtp_req_if.sink     req_if,
   dtp_rsp_if.source   rsp_if,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic                          in_valid_ff;
   logic [7:0]                    in_byte_ff;
   logic                          in_start_ff;
   dtp_pkg::dtp_cfg_type          cfg_ff;
   dtp_pkg::dtp_push_type         push;
   dtp_pkg::dtp_result_type       head;
   logic [dtp_pkg::RSP_CNT_W-1:0] fill_count;
   logic [dtp_pkg::RSP_CNT_W:0]   worst_fill;
   logic                          req_accept;
   logic                          rsp_pop;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            dtp_pkg::CSR_MATCH_CLASS:       cfg_ff.match_class       <= csr_wdata[1:0];
            dtp_pkg::CSR_MATCH_CONSTRUCTED: cfg_ff.match_constructed <= csr_wdata[0];
            dtp_pkg::CSR_MATCH_TAG:         cfg_ff.match_tag         <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Accept a byte only if the queue can absorb both the byte in flight
   // and this one, two results each.
   always_comb begin
      worst_fill = {1'b0, fill_count} +
                   (in_valid_ff ? (dtp_pkg::RSP_CNT_W + 1)'(4) : (dtp_pkg::RSP_CNT_W + 1)'(2));
   end
   assign req_if.ready = (worst_fill <= (dtp_pkg::RSP_CNT_W + 1)'(dtp_pkg::RSP_FIFO_DEPTH));
   assign req_accept   = req_if.valid && req_if.ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff  <= req_if.data_byte;
         in_start_ff <= req_if.frame_start;
      end
   end

   dtp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (in_valid_ff),
      .byte_data  (in_byte_ff),
      .byte_start (in_start_ff),
      .cfg        (cfg_ff),
      .push       (push)
   );

   assign rsp_pop = rsp_if.valid && rsp_if.ready;

   dtp_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_pop),
      .head       (head),
      .fill_count (fill_count)
   );

   // Result channel driven from the queue head.
   assign rsp_if.valid        = (fill_count != '0);
   assign rsp_if.kind         = head.kind;
   assign rsp_if.tag_class    = head.tag_class;
   assign rsp_if.constructed  = head.constructed;
   assign rsp_if.tag_number   = head.tag_number;
   assign rsp_if.length_value = head.length_value;
   assign rsp_if.matches_res  = head.matches_res;
   assign rsp_if.content_byte = head.content_byte;
   assign rsp_if.last_of_run  = head.last_of_run;
   assign rsp_if.int_value    = head.int_value;
   assign rsp_if.error_code   = head.error_code;

   // The queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      fill_count <= dtp_pkg::RSP_CNT_W'(dtp_pkg::RSP_FIFO_DEPTH))
      else $error("result queue overflow");

   // An accepted byte is in the input stage on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> in_valid_ff)
      else $error("accepted byte lost before the parse stage");

   // Results only appear in the queue for a byte held in the input stage.
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |=> fill_count <= $past(fill_count))
      else $error("queue grew without a byte to parse");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for der_tlv_header_parser_unit: drives DER byte streams,
// predicts every header, content, integer and error result and compares them in order.
// Depends on dtp_pkg, dtp_req_if, dtp_rsp_if and the parser RTL.
module tb_top;

   // Tag classes and the register index that the block does not implement.
   localparam logic [1:0] CLASS_UNIVERSAL   = 2'd0;
   localparam logic [1:0] CLASS_APPLICATION = 2'd1;
   localparam logic [1:0] CLASS_CONTEXT     = 2'd2;
   localparam logic [1:0] CLASS_PRIVATE     = 2'd3;
   localparam logic [1:0] CSR_UNUSED        = 2'd3;

   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned HOLD_CYCLES  = 60;
   localparam int unsigned DRAIN_SETTLE = 6;
   localparam int unsigned PHASE_ITEMS  = 66;
   localparam int unsigned MAX_SHOWN    = 10;

   typedef enum logic [2:0] {
      PH_IDENT, PH_TAG_EXT, PH_LEN_FIRST, PH_LEN_EXT, PH_BODY
   } parse_phase_type;

   // Predicts the result stream of the parser and checks what comes out against it.
   class der_header_scoreboard;
      dtp_pkg::dtp_cfg_type    cfg;
      parse_phase_type         phase;
      logic [31:0]             tag_acc;
      logic [2:0]              tag_seen;
      logic [1:0]              cls;
      logic                    form;
      logic [31:0]             len_acc;
      logic [6:0]              len_left;
      logic [31:0]             body_left;
      logic                    int_flag;
      logic [31:0]             int_acc;
      dtp_pkg::dtp_result_type expected_q[$];
      int unsigned             fail_count;
      int unsigned             kind_seen[4];
      int unsigned             match_seen;

      function new();
         cfg        = '0;
         phase      = PH_IDENT;
         tag_acc    = '0;
         tag_seen   = '0;
         cls        = '0;
         form       = 1'b0;
         len_acc    = '0;
         len_left   = '0;
         body_left  = '0;
         int_flag   = 1'b0;
         int_acc    = '0;
         fail_count = 0;
         match_seen = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
      endfunction

      function void write_reg(input logic [1:0] idx, input logic [31:0] data);
         case (idx)
            dtp_pkg::CSR_MATCH_CLASS:       cfg.match_class = data[1:0];
            dtp_pkg::CSR_MATCH_CONSTRUCTED: cfg.match_constructed = data[0];
            dtp_pkg::CSR_MATCH_TAG:         cfg.match_tag = data;
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void push_int(input logic [31:0] value);
         dtp_pkg::dtp_result_type r;
         r = '0;
         r.kind = dtp_pkg::KIND_INTEGER;
         r.int_value = value;
         expected_q.push_back(r);
      endfunction

      // An error drops the element; the next byte is read as an identifier.
      function void push_error(input logic [1:0] code);
         dtp_pkg::dtp_result_type r;
         r = '0;
         r.kind = dtp_pkg::KIND_ERROR;
         r.error_code = code;
         expected_q.push_back(r);
         phase = PH_IDENT;
      endfunction

      // Emit the header and decide whether primitive contents follow.
      function void close_header();
         dtp_pkg::dtp_result_type r;
         logic is_int;
         r = '0;
         r.kind = dtp_pkg::KIND_HEADER;
         r.tag_class = cls;
         r.constructed = form;
         r.tag_number = tag_acc;
         r.length_value = len_acc;
         r.matches_res = (cls == cfg.match_class && form == cfg.match_constructed &&
                          tag_acc == cfg.match_tag);
         expected_q.push_back(r);
         is_int = (cls == CLASS_UNIVERSAL && !form && tag_acc == dtp_pkg::TAG_INTEGER);
         phase = PH_IDENT;
         if (!form) begin
            if (len_acc == 0) begin
               if (is_int) push_int('0);
            end else begin
               body_left = len_acc;
               int_flag  = is_int;
               int_acc   = '0;
               phase     = PH_BODY;
            end
         end
      endfunction

      // Advance the parse state by one accepted stream byte.
      function void note_byte(input logic [7:0] b, input logic fs);
         dtp_pkg::dtp_result_type r;
         if (fs) phase = PH_IDENT;
         case (phase)
            PH_IDENT: begin
               cls      = b[7:6];
               form     = b[5];
               len_acc  = '0;
               len_left = '0;
               tag_seen = '0;
               if (b[4:0] == dtp_pkg::TAG_HIGH_FORM) begin
                  tag_acc = '0;
                  phase   = PH_TAG_EXT;
               end else begin
                  tag_acc = {27'd0, b[4:0]};
                  phase   = PH_LEN_FIRST;
               end
            end
            PH_TAG_EXT: begin
               if (tag_seen >= dtp_pkg::MAX_TAG_BYTES) begin
                  push_error(dtp_pkg::ERR_TAG_LONG);
               end else begin
                  tag_seen = tag_seen + 3'd1;
                  tag_acc  = {tag_acc[24:0], b[6:0]};
                  if (!b[7]) phase = PH_LEN_FIRST;
               end
            end
            PH_LEN_FIRST: begin
               if (!b[7]) begin
                  len_acc = {24'd0, b};
                  close_header();
               end else begin
                  len_acc = '0;
                  if (b[6:0] > dtp_pkg::MAX_LEN_BYTES) push_error(dtp_pkg::ERR_LEN_LONG);
                  else if (b[6:0] == 0) close_header();
                  else begin
                     len_left = b[6:0];
                     phase    = PH_LEN_EXT;
                  end
               end
            end
            PH_LEN_EXT: begin
               len_acc  = {len_acc[23:0], b};
               len_left = len_left - 7'd1;
               if (len_left == 0) close_header();
            end
            default: begin
               r = '0;
               r.kind = dtp_pkg::KIND_CONTENT;
               r.content_byte = b;
               r.last_of_run = (body_left == 1);
               expected_q.push_back(r);
               int_acc   = {int_acc[23:0], b};
               body_left = body_left - 32'd1;
               if (body_left == 0) begin
                  if (int_flag) push_int(int_acc);
                  phase = PH_IDENT;
               end
            end
         endcase
      endfunction

      function string show(input dtp_pkg::dtp_result_type r);
         return $sformatf({"kind %0d class %0d cons %0b tag %h len %h match %0b ",
                           "byte %h last %0b int %h err %0d"},
                          r.kind, r.tag_class, r.constructed, r.tag_number,
                          r.length_value, r.matches_res, r.content_byte,
                          r.last_of_run, r.int_value, r.error_code);
      endfunction

      // Compare one result transaction with the oldest prediction.
      function void check_result(input dtp_pkg::dtp_result_type got);
         dtp_pkg::dtp_result_type want;
         if (expected_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
               $display("Unexpected result at %0t: %s", $time, show(got));
            return;
         end
         want = expected_q.pop_front();
         kind_seen[want.kind]++;
         if (want.kind == dtp_pkg::KIND_HEADER && want.matches_res) match_seen++;
         if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN) begin
               $display("Result mismatch at %0t:", $time);
               $display("  expected %s", show(want));
               $display("  actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   dtp_req_if req_if();
   dtp_rsp_if rsp_if();

   der_tlv_header_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   der_header_scoreboard    sb;
   dtp_pkg::dtp_result_type rsp_seen;
   logic [8:0]              beat_q[$];
   int unsigned             send_idle_pct = 0;
   int unsigned             recv_idle_pct = 0;
   int unsigned             hold_left = 0;
   int unsigned             idle_cycles = 0;
   int unsigned             items_sent = 0;
   int unsigned             csr_writes = 0;
   logic                    hold_req = 1'b0;
   logic                    hold_ack = 1'b0;
   bit                      need_restart = 1'b0;

   always #10 clock = ~clock;

   // Receiver: random back-pressure, plus a long hold-off when one is requested.
   // A request is a toggle of hold_req; the receiver follows it with hold_ack.
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Monitor both channels and stop the run if traffic stalls for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            sb.note_byte(req_if.data_byte, req_if.frame_start);
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_seen.kind         = rsp_if.kind;
            rsp_seen.tag_class    = rsp_if.tag_class;
            rsp_seen.constructed  = rsp_if.constructed;
            rsp_seen.tag_number   = rsp_if.tag_number;
            rsp_seen.length_value = rsp_if.length_value;
            rsp_seen.matches_res  = rsp_if.matches_res;
            rsp_seen.content_byte = rsp_if.content_byte;
            rsp_seen.last_of_run  = rsp_if.last_of_run;
            rsp_seen.int_value    = rsp_if.int_value;
            rsp_seen.error_code   = rsp_if.error_code;
            sb.check_result(rsp_seen);
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("No transaction for %0d cycles, %0d results outstanding.",
                     IDLE_LIMIT, sb.pending());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // One register write per clock edge; the predictor follows at the same edge.
   task automatic csr_drive(input logic [1:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      csr_writes++;
   endtask

   task automatic apply_config(input logic [1:0] cls, input logic form,
                               input logic [31:0] tag, input bit poke_unused);
      csr_drive(dtp_pkg::CSR_MATCH_CLASS, {30'd0, cls});
      csr_drive(dtp_pkg::CSR_MATCH_CONSTRUCTED, {31'd0, form});
      csr_drive(dtp_pkg::CSR_MATCH_TAG, tag);
      if (poke_unused) csr_drive(CSR_UNUSED, $urandom);
      csr_we <= 1'b0;
   endtask

   // Offer one stream byte, with random gaps, and wait for it to be taken.
   task automatic send_byte(input logic [7:0] b, input logic fs);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.data_byte   <= b;
      req_if.frame_start <= fs;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   task automatic flush_beats();
      logic [8:0] beat;
      while (beat_q.size() != 0) begin
         beat = beat_q.pop_front();
         send_byte(beat[7:0], beat[8]);
      end
   endtask

   // Stop offering and let every predicted result come out, then settle.
   // The first edge lets the monitor note the last accepted byte.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   function automatic void put(input logic [7:0] b, input logic fs);
      beat_q.push_back({fs, b});
   endfunction

   // Identifier octets; tags of 31 and above (and some below) use the high-tag form.
   function automatic void put_ident(input logic [1:0] cls, input logic form,
                                     input logic [31:0] tag, input logic fs);
      logic [6:0]  groups[$];
      logic [31:0] rest;
      int          i;
      if (tag < 31 && $urandom_range(0, 7) != 0) begin
         put({cls, form, tag[4:0]}, fs);
      end else begin
         put({cls, form, dtp_pkg::TAG_HIGH_FORM}, fs);
         rest = tag;
         do begin
            groups.push_front(rest[6:0]);
            rest = rest >> 7;
         end while (rest != 0);
         if (groups.size() < dtp_pkg::MAX_TAG_BYTES && $urandom_range(0, 3) == 0)
            groups.push_front(7'd0);
         for (i = 0; i < groups.size(); i++)
            put({(i != groups.size() - 1), groups[i]}, 1'b0);
      end
   endfunction

   // Length octets in short form, or long form with an optional leading zero.
   function automatic void put_length(input logic [31:0] len, input bit long_form);
      int          n;
      int          i;
      logic [31:0] rest;
      if (!long_form && len < 128) begin
         put(len[7:0], 1'b0);
         return;
      end
      n    = 0;
      rest = len;
      while (rest != 0) begin
         n++;
         rest = rest >> 8;
      end
      if (n < dtp_pkg::MAX_LEN_BYTES && $urandom_range(0, 2) == 0) n++;
      put(8'h80 | 8'(n), 1'b0);
      for (i = n - 1; i >= 0; i--) put(8'(len >> (8 * i)), 1'b0);
   endfunction

   function automatic logic [31:0] rand_tag();
      case ($urandom_range(0, 3))
         0:       return 32'($urandom_range(0, 30));
         1:       return 32'($urandom_range(31, 127));
         2:       return 32'($urandom_range(128, 16383));
         default: return $urandom & 32'h0FFF_FFFF;
      endcase
   endfunction

   // Queue one random element: mostly well-formed, some broken or noise.
   function automatic void gen_element();
      int          sel;
      int          i;
      int          len;
      logic        fs;
      logic [1:0]  cls;
      logic        form;
      logic [31:0] tag;
      fs           = need_restart || ($urandom_range(0, 4) == 0);
      need_restart = 1'b0;
      cls          = 2'($urandom_range(0, 3));
      form         = 1'($urandom_range(0, 1));
      tag          = rand_tag();
      sel          = $urandom_range(0, 99);
      if (sel < 50) begin
         // Mostly a primitive element with contents; often INTEGER or a matching header.
         form = 1'b0;
         if ($urandom_range(0, 3) == 0) begin
            cls = CLASS_UNIVERSAL;
            tag = 32'(dtp_pkg::TAG_INTEGER);
         end else if ($urandom_range(0, 3) == 0 && sb.cfg.match_tag < 32'h1000_0000) begin
            cls  = sb.cfg.match_class;
            form = sb.cfg.match_constructed;
            tag  = sb.cfg.match_tag;
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
         put_ident(cls, form, tag, fs);
         put_length(32'(len), $urandom_range(0, 3) == 0);
         if (!form)
            for (i = 0; i < len; i++) put(8'($urandom_range(0, 255)), 1'b0);
      end else if (sel < 70) begin
         // Constructed header; whatever follows is parsed as nested elements.
         put_ident(cls, 1'b1, tag, fs);
         put_length(32'($urandom_range(0, 200)), $urandom_range(0, 2) == 0);
      end else if (sel < 78) begin
         // Four-byte length, a few content bytes, then abandoned by a frame start.
         put_ident(cls, 1'b0, tag, fs);
         put(8'h84, 1'b0);
         for (i = 0; i < 4; i++) put(8'($urandom_range(0, 255)), 1'b0);
         len = $urandom_range(0, 3);
         for (i = 0; i < len; i++) put(8'($urandom_range(0, 255)), 1'b0);
         need_restart = 1'b1;
      end else if (sel < 84) begin
         // Tag too long: four continuation bytes, the fifth byte is refused.
         put({cls, form, dtp_pkg::TAG_HIGH_FORM}, fs);
         for (i = 0; i < 4; i++) put({1'b1, 7'($urandom)}, 1'b0);
         put(8'($urandom_range(0, 255)), 1'b0);
      end else if (sel < 90) begin
         // Length field too long.
         put_ident(cls, form, tag, fs);
         put(8'($urandom_range('h85, 'hFF)), 1'b0);
      end else begin
         // Noise, sometimes with stray frame starts.
         len = $urandom_range(1, 4);
         for (i = 0; i < len; i++)
            put(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
         need_restart = 1'b1;
      end
   endfunction

   // Hand-picked streams covering the edges of the encoding.
   task automatic send_directed();
      int i;
      // Universal INTEGER of one byte, then an empty one.
      put(8'h02, 1'b1); put(8'h01, 1'b0); put(8'hFF, 1'b0);
      put(8'h02, 1'b0); put(8'h00, 1'b0);
      // Constructed SEQUENCE with a zero-count long-form length.
      put(8'h30, 1'b0); put(8'h80, 1'b0);
      // Private constructed high-tag identifier, tag 0xFF.
      put(8'hFF, 1'b0); put(8'h81, 1'b0); put(8'h7F, 1'b0); put(8'h00, 1'b0);
      // Tag too long, followed straight away by an element whose length field is too long.
      put(8'h1F, 1'b0);
      for (i = 0; i < 5; i++) put(8'h80, 1'b0);
      put(8'h04, 1'b0); put(8'h85, 1'b0);
      // Largest length value; the contents are left unfinished.
      put(8'h04, 1'b0); put(8'h84, 1'b0);
      for (i = 0; i < 4; i++) put(8'hFF, 1'b0);
      flush_beats();
   endtask

   initial begin
      int          p;
      int unsigned goal;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_if.valid       = 1'b0;
      req_if.data_byte   = '0;
      req_if.frame_start = 1'b0;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 36;
      recv_idle_pct = 78;
      apply_config(CLASS_UNIVERSAL, 1'b0, 32'(dtp_pkg::TAG_INTEGER), 1'b1);
      send_directed();
      wait_drained();

      // Random phases, each under its own match setting and one of three idling patterns.
      for (p = 0; p < 6; p++) begin
         case (p)
            0:       apply_config(CLASS_APPLICATION, 1'b0, 32'd5, 1'b0);
            1:       apply_config(CLASS_PRIVATE, 1'b1, 32'hFFFF_FFFF, 1'b1);
            2:       apply_config(CLASS_CONTEXT, 1'b1, 32'($urandom_range(31, 16383)), 1'b0);
            3:       apply_config(CLASS_UNIVERSAL, 1'b0, 32'(dtp_pkg::TAG_INTEGER), 1'b0);
            4:       apply_config(CLASS_PRIVATE, 1'b0, 32'h0FFF_FFFF, 1'b0);
            default: apply_config(CLASS_UNIVERSAL, 1'b1, 32'd0, 1'b1);
         endcase
         if (p < 2) begin
            send_idle_pct = 36;
            recv_idle_pct = 78;
         end else if (p < 4) begin
            send_idle_pct = 78;
            recv_idle_pct = 36;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // Hold the result side off so the queue fills and the input stalls.
         if (p == 1 || p == 4) hold_req <= ~hold_req;
         need_restart = 1'b1;
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            gen_element();
            flush_beats();
         end
         wait_drained();
      end

      $display("Sent %0d stream bytes under 7 match settings using %0d register writes.",
               items_sent, csr_writes);
      $display("Checked %0d headers (%0d matching), %0d content, %0d integer, %0d error results.",
               sb.kind_seen[dtp_pkg::KIND_HEADER], sb.match_seen,
               sb.kind_seen[dtp_pkg::KIND_CONTENT], sb.kind_seen[dtp_pkg::KIND_INTEGER],
               sb.kind_seen[dtp_pkg::KIND_ERROR]);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d failures, %0d results still outstanding.", sb.fail_count,
                  sb.pending());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/dtp_pkg.sv
rtl/dtp_req_if.sv
rtl/dtp_rsp_if.sv
rtl/dtp_parse.sv
rtl/dtp_rsp_fifo.sv
rtl/der_tlv_header_parser_unit.sv
test/tb_top.sv
